FILE: hw/rtl/smt_pkg.sv
// Shared types and constants for the score memo table.
// Used by smt_cell and score_memo_table_core; no dependencies.
package smt_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int NODES_DEF = 32;

  localparam int CNT_W   = 9;
  localparam int SCORE_W = 64;
  localparam int DROP_W  = 16;
  localparam int ID_W    = 5;
  localparam int PSET_IN_W = 32;

  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_CLEAR  = 2'd2
  } smt_mode_t;

  typedef enum logic [2:0] {
    ST_LOOKUP  = 3'd0,
    ST_STORED  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_ABORT   = 3'd3,
    ST_CLEARED = 3'd4
  } smt_status_t;

  // configuration register indexes
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_ENFORCE  = 1'b1;

  // one request travelling down the cell row, with its result fields
  typedef struct packed {
    logic                valid;
    logic                is_lookup;
    logic [CNT_W-1:0]    limit;
    logic                hit;
    logic [SCORE_W-1:0]  score;
    smt_status_t         status;
    logic [CNT_W-1:0]    used;
    logic                flag;
    logic [DROP_W-1:0]   drop;
  } smt_tok_t;

  // broadcast entry write
  typedef struct packed {
    logic                valid;
    logic [CNT_W-1:0]    idx;
    logic [SCORE_W-1:0]  score;
  } smt_wr_t;

endpackage

FILE: hw/rtl/smt_cell.sv
// One cell of the memo row: holds one entry and one stage of the request pipe.
// Depends on smt_pkg.
module smt_cell #(
  parameter int KEY_W = 37,
  parameter int IDX   = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  smt_pkg::smt_tok_t in_tok,
  input  logic [KEY_W-1:0]  in_key,
  output smt_pkg::smt_tok_t out_tok,
  output logic [KEY_W-1:0]  out_key,
  input  smt_pkg::smt_wr_t  wr,
  input  logic [KEY_W-1:0]  wr_key
);
  import smt_pkg::*;

  logic [KEY_W-1:0]   entry_key;
  logic [SCORE_W-1:0] entry_score;
  logic               match;
  smt_tok_t           tok_next;

  // only entries below the used count seen at issue take part
  assign match = in_tok.valid && in_tok.is_lookup && !in_tok.hit &&
                 (32'(in_tok.limit) > 32'(IDX)) && (in_key == entry_key);

  always_comb begin
    tok_next = in_tok;
    if (match) begin
      tok_next.hit   = 1'b1;
      tok_next.score = entry_score;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid && (32'(wr.idx) == 32'(IDX))) begin
      entry_key   <= wr_key;
      entry_score <= wr.score;
    end
  end

  // valid is the only field with a reset; payload just follows the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tok.valid <= 1'b0;
    end else if (advance) begin
      out_tok.valid <= tok_next.valid;
    end
    if (advance) begin
      out_tok.is_lookup <= tok_next.is_lookup;
      out_tok.limit     <= tok_next.limit;
      out_tok.hit       <= tok_next.hit;
      out_tok.score     <= tok_next.score;
      out_tok.status    <= tok_next.status;
      out_tok.used      <= tok_next.used;
      out_tok.flag      <= tok_next.flag;
      out_tok.drop      <= tok_next.drop;
      out_key           <= in_key;
    end
  end

endmodule

FILE: hw/rtl/score_memo_table_core.sv
// Top level of the score memo table: request decode, counters, cell row.
// Depends on smt_pkg and smt_cell.
//
// Append-only memo of 64-bit scores keyed by node id and parent set. Every
// request (lookup, store, clear) enters a row of DEPTH cells and walks one
// cell per cycle unless the output stalls, which freezes the whole row; each
// cell holds one entry and checks a passing lookup against it, so a lookup
// result is known when the request leaves the last cell. Store, clear and the
// counters are decided on acceptance and the outcome rides along with the
// request, so results come out in request order. Throughput is one request
// per cycle, except while the output stalls or new requests are held after a
// clear. After a clear, new requests wait until lookups accepted before the
// clear have left the row, since stores after a clear reuse low entries those
// lookups may still have to see. No clearing pass after reset; entries are
// only read below the used count.
module score_memo_table_core #(
  parameter int DEPTH = smt_pkg::DEPTH_DEF,
  parameter int NODES = smt_pkg::NODES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  // requests
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,   // node_id[4:0], parent_set[36:5], score_in[100:37]
  input  logic [1:0]    s_axis_tuser,   // mode[1:0]
  // results
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [95:0]   m_axis_tdata,   // score_out[63:0], entries_used[72:64],
                                        // overflowed[73], overflow_count[89:74]
  output logic [3:0]    m_axis_tuser,   // hit[0], status[3:1]
  // configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [8:0]    cfg_data
);
  import smt_pkg::*;

  localparam int PSET_W = (NODES >= PSET_IN_W) ? PSET_IN_W : NODES;
  localparam int KEY_W  = ID_W + PSET_W;
  localparam int LK_W   = $clog2(DEPTH + 2);

  // config registers
  logic [CNT_W-1:0] capacity;
  logic             enforce_limit;

  // table state
  logic [CNT_W-1:0]  used_count, used_count_next;
  logic              full_flag, full_flag_next;
  logic [DROP_W-1:0] dropped_count, dropped_count_next;

  // lookups in flight and the post-clear hold
  logic [LK_W-1:0] lk_cnt;
  logic            dirty;
  logic            hold;

  logic advance;
  logic accept;

  smt_tok_t         tok  [DEPTH+1];
  logic [KEY_W-1:0] keys [DEPTH+1];

  smt_tok_t         new_tok;
  smt_wr_t          wr;
  logic [KEY_W-1:0] req_key;
  logic [CNT_W-1:0] limit;
  logic [1:0]       mode;
  logic             lk_in, lk_out;

  assign mode    = s_axis_tuser;
  assign req_key = {s_axis_tdata[4:0], s_axis_tdata[5 +: PSET_W]};

  // usable limit saturates at the row length
  assign limit = (32'(capacity) > 32'(DEPTH)) ? CNT_W'(DEPTH) : capacity;

  assign advance       = !tok[DEPTH].valid || m_axis_tready;
  assign hold          = dirty && (lk_cnt != '0);
  assign s_axis_tready = advance && !hold;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // decode one request into its state update and result fields
  always_comb begin
    used_count_next    = used_count;
    full_flag_next     = full_flag;
    dropped_count_next = dropped_count;
    wr.valid           = 1'b0;
    wr.idx             = used_count;
    wr.score           = s_axis_tdata[100:37];
    new_tok.valid      = accept;
    new_tok.is_lookup  = 1'b0;
    new_tok.limit      = used_count;
    new_tok.hit        = 1'b0;
    new_tok.score      = '0;
    new_tok.status     = ST_LOOKUP;
    case (mode)
      MODE_LOOKUP: begin
        new_tok.is_lookup = 1'b1;
      end
      MODE_STORE: begin
        if (used_count < limit) begin
          wr.valid        = accept;
          used_count_next = used_count + 1'b1;
          new_tok.status  = ST_STORED;
        end else if (enforce_limit) begin
          new_tok.status = ST_ABORT;
        end else begin
          full_flag_next = 1'b1;
          if (dropped_count != DROP_MAX) begin
            dropped_count_next = dropped_count + 1'b1;
          end
          new_tok.status = ST_DROPPED;
        end
      end
      MODE_CLEAR: begin
        used_count_next    = '0;
        full_flag_next     = 1'b0;
        dropped_count_next = '0;
        new_tok.status     = ST_CLEARED;
      end
      default: begin
        // undefined mode: no change, status lookup-done, no hit
      end
    endcase
    new_tok.used = used_count_next;
    new_tok.flag = full_flag_next;
    new_tok.drop = dropped_count_next;
  end

  assign tok[0]  = new_tok;
  assign keys[0] = req_key;

  assign lk_in  = accept && (mode == MODE_LOOKUP);
  assign lk_out = advance && tok[DEPTH].valid && tok[DEPTH].is_lookup;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CNT_W'(256);
      enforce_limit <= 1'b0;
      used_count    <= '0;
      full_flag     <= 1'b0;
      dropped_count <= '0;
      lk_cnt        <= '0;
      dirty         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAPACITY: capacity      <= cfg_data;
          CFG_ENFORCE:  enforce_limit <= cfg_data[0];
          default:      ;
        endcase
      end
      if (accept) begin
        used_count    <= used_count_next;
        full_flag     <= full_flag_next;
        dropped_count <= dropped_count_next;
      end
      case ({lk_in, lk_out})
        2'b10:   lk_cnt <= lk_cnt + 1'b1;
        2'b01:   lk_cnt <= lk_cnt - 1'b1;
        default: ;
      endcase
      // hold off new requests after a clear until older lookups drain
      if (accept && (mode == MODE_CLEAR)) begin
        dirty <= 1'b1;
      end else if (lk_cnt == '0) begin
        dirty <= 1'b0;
      end
    end
  end

  // the cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    smt_cell #(
      .KEY_W (KEY_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .in_tok  (tok[i]),
      .in_key  (keys[i]),
      .out_tok (tok[i+1]),
      .out_key (keys[i+1]),
      .wr      (wr),
      .wr_key  (req_key)
    );
  end

  // last cell doubles as the output register
  assign m_axis_tvalid = tok[DEPTH].valid;
  assign m_axis_tdata  = {6'd0, tok[DEPTH].drop, tok[DEPTH].flag,
                          tok[DEPTH].used, tok[DEPTH].score};
  assign m_axis_tuser  = {tok[DEPTH].status, tok[DEPTH].hit};

endmodule
